@@ rtl/mpel_pkg.sv @@
// shared constants, register codes and helper functions of the eight lane max pool unit
`timescale 1ns / 1ps
package mpel_pkg;

   // lane and field widths
   localparam int LANES = 8;
   localparam int LANE_W = 16;
   localparam int MAX_W = 15;
   localparam int DATA_W = LANES * LANE_W;
   localparam int OUT_W = LANES * MAX_W;

   // plane and window limits
   localparam int MAX_COLS = 256;
   localparam int MAX_ROWS = 256;
   localparam int MAX_POOL = 4;
   localparam int MAX_STRIDE = 4;

   // position and store address widths
   localparam int POS_W = 8;
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_SEL_W = $clog2(MAX_POOL);
   localparam int ADDR_W = ROW_SEL_W + COL_W;
   localparam int STORE_DEPTH = MAX_POOL * MAX_COLS;

   // register widths
   localparam int SIZE_W = 9;
   localparam int POOL_W = 3;
   localparam int PHASE_W = 2;
   localparam int SUM_W = SIZE_W + 1;

   // register index codes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] REG_IN_ROWS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IN_COLS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_WIN_SIDE = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_STRIDE = 2'd3;

   // plane size limited to 1..hi
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // pool size or stride limited to 1..hi
   function automatic logic [POOL_W-1:0] clamp_small(input logic [POOL_W-1:0] v,
                                                     input logic [POOL_W-1:0] hi);
      logic [POOL_W-1:0] r;
      if (v == '0) begin
         r = POOL_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // stride phase advance with wrap
   function automatic logic [PHASE_W-1:0] phase_step(input logic [PHASE_W-1:0] ph,
                                                     input logic [POOL_W-1:0] s);
      logic [POOL_W-1:0] nxt;
      nxt = {1'b0, ph} + POOL_W'(1);
      return (nxt >= s) ? '0 : nxt[PHASE_W-1:0];
   endfunction

endpackage

@@ rtl/mpel_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mpel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/max_pool_eight_lane_unit.sv @@
// Eight lane streaming 2-D max pooling unit.
//
// Pixels of eight Q8.8 signed lanes enter on the req_ channel in raster
// order, one plane after another; lane 0 sits in the low bits of tdata.
// Each pixel is written to a line store of the last four rows (one ram word
// per pixel, all lanes side by side). When a pixel closes a pool window at
// stride alignment, a small sequencer reads the window back one pixel per
// cycle through the ram read port and folds it into eight lane comparators.
// The result (per lane maximum, floored at zero) leaves on the rsp_ channel,
// with tlast marking the last window of the plane.
// A pixel that closes no window leaves the unit ready, so such pixels can
// arrive back to back. A window pixel is followed by the window walk in
// S_WALK, a fold in S_FOLD and the result in S_SEND, where rsp_tvalid
// rises; no new item is taken before the unit is back in S_IDLE. The ram
// read port (one window pixel a cycle) sets the length of the walk.
// req_tready stays low from acceptance of a window pixel until its result is
// taken, so a stalled receiver holds the input side as well.
// Reset clears positions and phases and loads in_rows 1, in_cols 1,
// window side 2, stride 2; the line store needs no clearing pass.
// The user must write csr_ registers only while idle; no check enforces it.
`timescale 1ns / 1ps
module max_pool_eight_lane_unit (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write port
   input  logic                               csr_we,
   input  logic [mpel_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mpel_pkg::SIZE_W-1:0]        csr_wdata,
   // pixel input: lane0 .. lane7, 16 bits each, lowest first
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mpel_pkg::DATA_W-1:0]        req_tdata,
   // window result: max0 .. max7, 15 bits each, lowest first
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mpel_pkg::OUT_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast
);

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_FOLD, S_SEND} state_type;
   typedef logic [mpel_pkg::MAX_W-1:0] best_type [mpel_pkg::LANES];

   // configuration registers
   logic [mpel_pkg::SIZE_W-1:0] in_rows_ff, in_rows_in;
   logic [mpel_pkg::SIZE_W-1:0] in_cols_ff, in_cols_in;
   logic [mpel_pkg::POOL_W-1:0] win_side_ff, win_side_in;
   logic [mpel_pkg::POOL_W-1:0] stride_ff, stride_in;

   // scan position state
   logic [mpel_pkg::POS_W-1:0]   row_pos_ff, row_pos_in;
   logic [mpel_pkg::POS_W-1:0]   col_pos_ff, col_pos_in;
   logic [mpel_pkg::PHASE_W-1:0] row_phase_ff, row_phase_in;
   logic [mpel_pkg::PHASE_W-1:0] col_phase_ff, col_phase_in;

   // sequencer state
   state_type                      state_ff, state_in;
   logic [mpel_pkg::ROW_SEL_W-1:0] row_sel_ff, row_sel_in;
   logic [mpel_pkg::COL_W-1:0]     col_lat_ff, col_lat_in;
   logic [mpel_pkg::ROW_SEL_W-1:0] pm1_ff, pm1_in;
   logic [mpel_pkg::ROW_SEL_W-1:0] wi_ff, wi_in;
   logic [mpel_pkg::ROW_SEL_W-1:0] wj_ff, wj_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic                           done_ff, done_in;
   best_type                       best_ff, best_in;

   // derived values
   logic [mpel_pkg::SIZE_W-1:0] rows_eff, cols_eff;
   logic [mpel_pkg::POOL_W-1:0] pool_eff, stride_eff;
   logic [mpel_pkg::SUM_W-1:0]  r_next, c_next;
   logic                        accept, fire, col_wrap, row_full, col_full;
   logic                        walk_last;
   logic [mpel_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [mpel_pkg::DATA_W-1:0] rd_data;
   logic [mpel_pkg::ROW_SEL_W-1:0] rd_row;
   logic [mpel_pkg::COL_W-1:0]     rd_col;

   assign rows_eff = mpel_pkg::clamp_size(in_rows_ff, mpel_pkg::SIZE_W'(mpel_pkg::MAX_ROWS));
   assign cols_eff = mpel_pkg::clamp_size(in_cols_ff, mpel_pkg::SIZE_W'(mpel_pkg::MAX_COLS));
   assign pool_eff = mpel_pkg::clamp_small(win_side_ff, mpel_pkg::POOL_W'(mpel_pkg::MAX_POOL));
   assign stride_eff = mpel_pkg::clamp_small(stride_ff, mpel_pkg::POOL_W'(mpel_pkg::MAX_STRIDE));

   assign accept = req_tvalid && req_tready;
   assign r_next = mpel_pkg::SUM_W'(row_pos_ff) + mpel_pkg::SUM_W'(1);
   assign c_next = mpel_pkg::SUM_W'(col_pos_ff) + mpel_pkg::SUM_W'(1);
   assign row_full = r_next >= mpel_pkg::SUM_W'(pool_eff);
   assign col_full = c_next >= mpel_pkg::SUM_W'(pool_eff);
   assign col_wrap = c_next >= mpel_pkg::SUM_W'(cols_eff);
   assign fire = row_full && col_full && (row_phase_ff == '0) && (col_phase_ff == '0);

   // line store: one word per pixel, row modulo the pool limit
   assign wr_addr = {row_pos_ff[mpel_pkg::ROW_SEL_W-1:0], col_pos_ff[mpel_pkg::COL_W-1:0]};
   assign rd_row = row_sel_ff + wi_ff - pm1_ff;
   assign rd_col = col_lat_ff + mpel_pkg::COL_W'(wj_ff) - mpel_pkg::COL_W'(pm1_ff);
   assign rd_addr = {rd_row, rd_col};
   assign walk_last = (wi_ff == pm1_ff) && (wj_ff == pm1_ff);

   mpel_ram #(
      .WIDTH (mpel_pkg::DATA_W),
      .DEPTH (mpel_pkg::STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (state_ff == S_WALK),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state of registers, positions and sequencer
   always_comb begin
      in_rows_in = in_rows_ff;
      in_cols_in = in_cols_ff;
      win_side_in = win_side_ff;
      stride_in = stride_ff;
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      row_phase_in = row_phase_ff;
      col_phase_in = col_phase_ff;
      state_in = state_ff;
      row_sel_in = row_sel_ff;
      col_lat_in = col_lat_ff;
      pm1_in = pm1_ff;
      wi_in = wi_ff;
      wj_in = wj_ff;
      rd_valid_in = 1'b0;
      done_in = done_ff;
      best_in = best_ff;

      // register writes
      if (csr_we) begin
         case (csr_addr)
            mpel_pkg::REG_IN_ROWS: in_rows_in = csr_wdata;
            mpel_pkg::REG_IN_COLS: in_cols_in = csr_wdata;
            mpel_pkg::REG_WIN_SIDE: win_side_in = csr_wdata[mpel_pkg::POOL_W-1:0];
            mpel_pkg::REG_STRIDE: stride_in = csr_wdata[mpel_pkg::POOL_W-1:0];
            default: ;
         endcase
      end

      // fold the word read last cycle into the running maxima
      if (rd_valid_ff) begin
         for (int l = 0; l < mpel_pkg::LANES; l++) begin
            if (!rd_data[l*mpel_pkg::LANE_W + mpel_pkg::MAX_W] &&
                rd_data[l*mpel_pkg::LANE_W +: mpel_pkg::MAX_W] > best_ff[l]) begin
               best_in[l] = rd_data[l*mpel_pkg::LANE_W +: mpel_pkg::MAX_W];
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // advance scan position and stride phases
               if (col_full) begin
                  col_phase_in = mpel_pkg::phase_step(col_phase_ff, stride_eff);
               end
               if (col_wrap) begin
                  col_pos_in = '0;
                  col_phase_in = '0;
                  if (row_full) begin
                     row_phase_in = mpel_pkg::phase_step(row_phase_ff, stride_eff);
                  end
                  if (r_next >= mpel_pkg::SUM_W'(rows_eff)) begin
                     row_pos_in = '0;
                     row_phase_in = '0;
                  end else begin
                     row_pos_in = r_next[mpel_pkg::POS_W-1:0];
                  end
               end else begin
                  col_pos_in = c_next[mpel_pkg::POS_W-1:0];
               end
               // window closes here: latch corner and start the walk
               if (fire) begin
                  row_sel_in = row_pos_ff[mpel_pkg::ROW_SEL_W-1:0];
                  col_lat_in = col_pos_ff[mpel_pkg::COL_W-1:0];
                  pm1_in = mpel_pkg::ROW_SEL_W'(pool_eff - mpel_pkg::POOL_W'(1));
                  wi_in = '0;
                  wj_in = '0;
                  done_in = (mpel_pkg::SUM_W'(row_pos_ff) + mpel_pkg::SUM_W'(stride_eff)
                             >= mpel_pkg::SUM_W'(rows_eff)) &&
                            (mpel_pkg::SUM_W'(col_pos_ff) + mpel_pkg::SUM_W'(stride_eff)
                             >= mpel_pkg::SUM_W'(cols_eff));
                  for (int l = 0; l < mpel_pkg::LANES; l++) begin
                     best_in[l] = '0;
                  end
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            // one window pixel read per cycle
            rd_valid_in = 1'b1;
            if (walk_last) begin
               state_in = S_FOLD;
            end else if (wj_ff == pm1_ff) begin
               wj_in = '0;
               wi_in = wi_ff + mpel_pkg::ROW_SEL_W'(1);
            end else begin
               wj_in = wj_ff + mpel_pkg::ROW_SEL_W'(1);
            end
         end
         S_FOLD: begin
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         in_rows_ff <= mpel_pkg::SIZE_W'(1);
         in_cols_ff <= mpel_pkg::SIZE_W'(1);
         win_side_ff <= mpel_pkg::POOL_W'(2);
         stride_ff <= mpel_pkg::POOL_W'(2);
         row_pos_ff <= '0;
         col_pos_ff <= '0;
         row_phase_ff <= '0;
         col_phase_ff <= '0;
         state_ff <= S_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         in_rows_ff <= in_rows_in;
         in_cols_ff <= in_cols_in;
         win_side_ff <= win_side_in;
         stride_ff <= stride_in;
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
         row_phase_ff <= row_phase_in;
         col_phase_ff <= col_phase_in;
         state_ff <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
      row_sel_ff <= row_sel_in;
      col_lat_ff <= col_lat_in;
      pm1_ff <= pm1_in;
      wi_ff <= wi_in;
      wj_ff <= wj_in;
      done_ff <= done_in;
      best_ff <= best_in;
   end

   // channel outputs
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_SEND);
   assign rsp_tlast = done_ff;
   always_comb begin
      for (int l = 0; l < mpel_pkg::LANES; l++) begin
         rsp_tdata[l*mpel_pkg::MAX_W +: mpel_pkg::MAX_W] = best_ff[l];
      end
   end

   // never take an item while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while result pending");

   // read data only arrives during or right after the walk
   a_read_window: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_WALK || state_ff == S_FOLD))
      else $error("line store read outside window walk");

   // a pixel that closes no window leaves the unit ready
   a_no_window_ready: assert property (@(posedge clock) disable iff (reset)
      (accept && !fire) |=> req_tready)
      else $error("unit stalled after pixel with no window");

   // a window pixel starts the walk
   a_window_walk: assert property (@(posedge clock) disable iff (reset)
      (accept && fire) |=> (state_ff == S_WALK))
      else $error("window pixel did not start walk");

   // a taken result frees the input side
   a_result_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("unit not ready after result taken");

endmodule
